// ===== src/fctm_pkg.sv =====
// ----------------------------------------------------------------------------
// fctm_pkg
// Shared sizes, types and constants of the four channel trimmed mean core.
// ----------------------------------------------------------------------------
`default_nettype none

package fctm_pkg;

    // round size and trim
    localparam int SAMPLE_COUNT  = 16;
    localparam int DROPPED_COUNT = 8;
    localparam int SAMPLE_WIDTH  = 24;
    localparam int DROP_EACH     = DROPPED_COUNT / 2;
    localparam int KEPT_COUNT    = SAMPLE_COUNT - 2 * DROP_EACH;
    // divisor guarded so that an empty kept range still elaborates
    localparam int KEPT_DIV      = (KEPT_COUNT > 0) ? KEPT_COUNT : 1;

    // port field widths
    localparam int IN_W      = 24;
    localparam int MEAN_W    = 28;
    localparam int TOTAL_W   = 30;
    localparam int FRAC_BITS = 4;

    // internal widths
    localparam int CNT_W    = $clog2(SAMPLE_COUNT);
    localparam int ACC_W    = SAMPLE_WIDTH + CNT_W + 1;
    localparam int SCALED_W = ACC_W + FRAC_BITS;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [MEAN_W-1:0]       t_mean;
    typedef logic signed [TOTAL_W-1:0]      t_total;

    // control from the sequencer to each channel chain
    typedef struct packed {
        logic insert;     // a sample enters the first cell
        logic shift;      // every cell takes its right neighbor's value
        logic acc_clear;  // zero the kept-sample sum
        logic acc_en;     // add the head cell to the sum
    } t_chain_ctrl;

endpackage

`default_nettype wire

// ===== src/four_channel_trimmed_mean_core.sv =====
// ----------------------------------------------------------------------------
// four_channel_trimmed_mean_core
// Trimmed mean of four load-cell channels over rounds of acquisitions.
// ----------------------------------------------------------------------------
// A round takes SAMPLE_COUNT (16) acquisitions, one per cycle at full input
// rate; each is sorted on the fly into a row of 16 cells per channel. After
// the last transfer of a round the input stalls while the row settles (until
// no value is still moving), then the row drains one cell per cycle, summing
// the middle eight, and the result register is loaded with the four means
// (4 fraction bits, truncated toward zero, saturated to 28 bits) and their
// sum. The result waits in its register while the next round is collected;
// a round only finishes once that register is free.
`default_nettype none

module four_channel_trimmed_mean_core
    import fctm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic signed [IN_W-1:0] i_sample_front_left,
    input  wire logic signed [IN_W-1:0] i_sample_front_right,
    input  wire logic signed [IN_W-1:0] i_sample_rear_left,
    input  wire logic signed [IN_W-1:0] i_sample_rear_right,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_mean                      o_mean_front_left,
    output t_mean                      o_mean_front_right,
    output t_mean                      o_mean_rear_left,
    output t_mean                      o_mean_rear_right,
    output t_total                     o_total_weight
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_SETTLE  = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    localparam logic [CNT_W:0] KEEP_LO = (CNT_W+1)'(DROP_EACH);
    localparam logic [CNT_W:0] KEEP_HI = (CNT_W+1)'(SAMPLE_COUNT - DROP_EACH);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    t_mean            r_mean [4];
    t_total           r_total;

    logic        w_accept;
    logic        w_load;
    logic        w_last;
    t_chain_ctrl w_ctrl;
    logic [3:0]  w_busy;
    t_mean       w_mean   [4];
    t_sample     w_sample [4];
    t_total      w_total;

    assign o_ready  = (r_state == ST_COLLECT);
    assign w_accept = i_valid && o_ready;
    assign w_last   = (r_cnt == CNT_W'(SAMPLE_COUNT - 1));
    assign w_load   = (r_state == ST_FINISH) && (!r_out_valid || i_ready);

    // only the low sample bits carry the reading
    assign w_sample[0] = i_sample_front_left[SAMPLE_WIDTH-1:0];
    assign w_sample[1] = i_sample_front_right[SAMPLE_WIDTH-1:0];
    assign w_sample[2] = i_sample_rear_left[SAMPLE_WIDTH-1:0];
    assign w_sample[3] = i_sample_rear_right[SAMPLE_WIDTH-1:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_COLLECT: begin
                if (w_accept) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (w_last) begin
                        n_cnt   = '0;
                        n_state = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                if (w_busy == 4'b0000) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last) begin
                    n_cnt   = '0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_load) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // chain control
    always_comb begin
        w_ctrl.insert    = w_accept;
        w_ctrl.shift     = (r_state == ST_DRAIN);
        w_ctrl.acc_clear = (r_state == ST_SETTLE);
        w_ctrl.acc_en    = (r_state == ST_DRAIN) &&
                           ({1'b0, r_cnt} >= KEEP_LO) && ({1'b0, r_cnt} < KEEP_HI);
    end

    // one chain per channel
    for (genvar c = 0; c < 4; c++) begin : g_chan
        fctm_chain u_chain (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_sample (w_sample[c]),
            .o_busy   (w_busy[c]),
            .o_mean   (w_mean[c])
        );
    end

    // total of the four reported means
    assign w_total = TOTAL_W'(w_mean[0]) + TOTAL_W'(w_mean[1])
                   + TOTAL_W'(w_mean[2]) + TOTAL_W'(w_mean[3]);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mean  <= w_mean;
            r_total <= w_total;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_mean_front_left  = r_mean[0];
    assign o_mean_front_right = r_mean[1];
    assign o_mean_rear_left   = r_mean[2];
    assign o_mean_rear_right  = r_mean[3];
    assign o_total_weight     = r_total;

endmodule

`default_nettype wire

// ===== src/fctm_cell.sv =====
// ----------------------------------------------------------------------------
// fctm_cell
// One sorting cell: keeps the smaller of its value and an incoming one and
// hands the larger to its right neighbor; in drain mode it shifts left.
// ----------------------------------------------------------------------------
`default_nettype none

module fctm_cell
    import fctm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_shift,
    input  wire logic    i_in_valid,
    input  wire t_sample i_in_data,
    input  wire logic    i_right_valid,
    input  wire t_sample i_right_data,
    output logic         o_valid,
    output t_sample      o_data,
    output logic         o_pass_valid,
    output t_sample      o_pass_data
);

    logic    r_valid;
    t_sample r_data;
    logic    r_pass_valid;
    t_sample r_pass_data;

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pass_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid      <= i_right_valid;
            r_pass_valid <= 1'b0;
        end else if (i_in_valid) begin
            r_valid      <= 1'b1;
            r_pass_valid <= r_valid;
        end else begin
            r_pass_valid <= 1'b0;
        end
    end

    // held value and the value handed right
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_right_data;
        end else if (i_in_valid) begin
            if (!r_valid) begin
                r_data <= i_in_data;
            end else if (i_in_data < r_data) begin
                r_data      <= i_in_data;
                r_pass_data <= r_data;
            end else begin
                r_pass_data <= i_in_data;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_data       = r_data;
    assign o_pass_valid = r_pass_valid;
    assign o_pass_data  = r_pass_data;

endmodule

`default_nettype wire

// ===== src/fctm_chain.sv =====
// ----------------------------------------------------------------------------
// fctm_chain
// One channel: a row of sorting cells, the kept-sample accumulator and the
// scaling of the sum into a saturated fixed point mean.
// ----------------------------------------------------------------------------
`default_nettype none

module fctm_chain
    import fctm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_chain_ctrl i_ctrl,
    input  wire t_sample     i_sample,
    output logic             o_busy,
    output t_mean            o_mean
);

    localparam logic signed [SCALED_W-1:0] MEAN_HI = SCALED_W'((1 <<< (MEAN_W - 1)) - 1);
    localparam logic signed [SCALED_W-1:0] MEAN_LO = -MEAN_HI - SCALED_W'(1);
    localparam logic signed [SCALED_W-1:0] DIV     = SCALED_W'(KEPT_DIV);

    logic [SAMPLE_COUNT-1:0] w_valid;
    logic [SAMPLE_COUNT-1:0] w_pass_valid;
    t_sample                 w_data      [SAMPLE_COUNT];
    t_sample                 w_pass_data [SAMPLE_COUNT];

    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SCALED_W-1:0] w_scaled;
    logic signed [SCALED_W-1:0] w_quot;

    // row of cells, inserts move right, drain moves left
    for (genvar g = 0; g < SAMPLE_COUNT; g++) begin : g_cell
        logic    w_in_valid;
        t_sample w_in_data;
        logic    w_right_valid;
        t_sample w_right_data;

        if (g == 0) begin : g_head
            assign w_in_valid = i_ctrl.insert;
            assign w_in_data  = i_sample;
        end else begin : g_body
            assign w_in_valid = w_pass_valid[g-1];
            assign w_in_data  = w_pass_data[g-1];
        end

        if (g == SAMPLE_COUNT - 1) begin : g_tail
            assign w_right_valid = 1'b0;
            assign w_right_data  = '0;
        end else begin : g_link
            assign w_right_valid = w_valid[g+1];
            assign w_right_data  = w_data[g+1];
        end

        fctm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (i_ctrl.shift),
            .i_in_valid    (w_in_valid),
            .i_in_data     (w_in_data),
            .i_right_valid (w_right_valid),
            .i_right_data  (w_right_data),
            .o_valid       (w_valid[g]),
            .o_data        (w_data[g]),
            .o_pass_valid  (w_pass_valid[g]),
            .o_pass_data   (w_pass_data[g])
        );
    end

    // values still moving through the row
    assign o_busy = |w_pass_valid;

    // sum of the kept samples as they leave the head cell
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en && w_valid[0]) begin
            r_acc <= r_acc + ACC_W'(w_data[0]);
        end
    end

    // scale by sixteen, divide by the kept count toward zero, saturate
    assign w_scaled = SCALED_W'(r_acc) <<< FRAC_BITS;
    assign w_quot   = w_scaled / DIV;

    always_comb begin
        if (w_quot > MEAN_HI) begin
            o_mean = MEAN_HI[MEAN_W-1:0];
        end else if (w_quot < MEAN_LO) begin
            o_mean = MEAN_LO[MEAN_W-1:0];
        end else begin
            o_mean = w_quot[MEAN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/fctm_checker.sv =====
// ----------------------------------------------------------------------------
// fctm_checker
// Port-level checks of the trimmed mean core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fctm_checker
    import fctm_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_ready,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire t_mean                  o_mean_front_left,
    input wire t_mean                  o_mean_front_right,
    input wire t_mean                  o_mean_rear_left,
    input wire t_mean                  o_mean_rear_right,
    input wire t_total                 o_total_weight
);

    t_total w_sum;

    assign w_sum = TOTAL_W'(o_mean_front_left) + TOTAL_W'(o_mean_front_right)
                 + TOTAL_W'(o_mean_rear_left) + TOTAL_W'(o_mean_rear_right);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_total_weight)
                                && $stable(o_mean_front_left))
        else $error("stalled result changed");

    // total is the sum of the four means
    a_total_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_total_weight == w_sum)
        else $error("total does not match the means");

    // a result appears only after the input stalled for the round's end
    a_result_after_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result without end of round");

endmodule

bind four_channel_trimmed_mean_core fctm_checker u_fctm_checker (.*);

`default_nettype wire
